[rtl/hand_pad_debounce_command_decoder_top_defines.svh]
// assertion macros shared by the hand-pad decoder rtl
`ifndef HAND_PAD_DEBOUNCE_COMMAND_DECODER_TOP_DEFINES_SVH
`define HAND_PAD_DEBOUNCE_COMMAND_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/hpd_pkg.sv]
// types, register codes and constants of the hand-pad decoder
`default_nettype none
package hpd_pkg;

    localparam int KEY_W   = 7;
    localparam int TICK_W  = 32;
    localparam int SPEED_W = 16;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // key bit positions, active high after inversion
    localparam int KEY_1  = 0;
    localparam int KEY_2  = 1;
    localparam int KEY_3  = 2;
    localparam int KEY_4  = 3;
    localparam int KEY_5  = 4;
    localparam int KEY_6  = 5;
    localparam int KEY_SW = 6;

    // axis command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECEL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERING_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEST_DIR        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EAST_DIR        = 3'd4;

    // configuration reset values
    localparam logic [TICK_W-1:0]  RST_DEBOUNCE_TICKS  = 32'd1000;
    localparam logic [SPEED_W-1:0] RST_FAST_SPEED      = 16'd1000;
    localparam logic [SPEED_W-1:0] RST_CENTERING_SPEED = 16'd10;
    localparam logic               RST_WEST_DIR        = 1'b0;
    localparam logic               RST_EAST_DIR        = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   raw_keys_n;
        logic [TICK_W-1:0]  tick_now;
        logic               move_active;
        logic               parked;
        logic [SPEED_W-1:0] current_max_speed;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0]   stable_keys;
        logic [CMD_W-1:0]   ra_cmd;
        logic               ra_dir;
        logic [CMD_W-1:0]   dec_cmd;
        logic               dec_dir;
        logic               speed_write;
        logic [SPEED_W-1:0] speed_value;
        logic               unpark_req;
        logic               save_req;
        logic               north_dir;
        logic               bright_up;
        logic               bright_down;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0]  debounce_ticks;
        logic [SPEED_W-1:0] fast_speed;
        logic [SPEED_W-1:0] centering_speed;
        logic               west_dir;
        logic               east_dir;
    } t_cfg;

endpackage
`default_nettype wire

[rtl/hpd_debounce.sv]
// debounce timer: tracks key changes and decides acceptance of a new key state
`default_nettype none
module hpd_debounce
    import hpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [KEY_W-1:0]  i_keys,
    input  wire logic [TICK_W-1:0] i_tick,
    input  wire logic [TICK_W-1:0] i_debounce_ticks,
    output logic                   o_accept,
    output logic [KEY_W-1:0]       o_stable_keys
);

    logic [KEY_W-1:0]  r_last_raw;
    logic [KEY_W-1:0]  r_accepted;
    logic [TICK_W-1:0] r_change_tick;
    logic [TICK_W-1:0] n_change_tick;
    logic [TICK_W-1:0] elapsed;

    // restart the timer on any change, elapsed time wraps mod 2^32
    always_comb begin
        n_change_tick = (i_keys != r_last_raw) ? i_tick : r_change_tick;
        elapsed       = i_tick - n_change_tick;
        o_accept      = (elapsed > i_debounce_ticks) && (i_keys != r_accepted);
        o_stable_keys = o_accept ? i_keys : r_accepted;
    end

    // key history, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= '0;
            r_accepted    <= '0;
            r_change_tick <= '0;
        end else if (i_advance) begin
            r_last_raw    <= i_keys;
            r_accepted    <= o_stable_keys;
            r_change_tick <= n_change_tick;
        end
    end

endmodule
`default_nettype wire

[rtl/hpd_decode.sv]
// command decoder: turns an accepted key state into axis, speed and pulse outputs
`default_nettype none
module hpd_decode
    import hpd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic             i_accept,
    input  wire logic [KEY_W-1:0] i_stable_keys,
    input  wire t_in_item         i_item,
    input  wire t_cfg             i_cfg,
    output t_out_item             o_result
);

    logic [SPEED_W-1:0] r_saved_speed;
    logic [SPEED_W-1:0] n_saved_speed;
    logic               r_north_bit;
    logic               n_north_bit;
    logic [SPEED_W-1:0] manual_speed;
    logic [KEY_W-1:0]   k;

    // decode of the newly accepted keys
    always_comb begin
        k             = i_stable_keys;
        manual_speed  = k[KEY_SW] ? i_cfg.fast_speed : i_cfg.centering_speed;
        n_saved_speed = r_saved_speed;
        n_north_bit   = r_north_bit;

        o_result             = '0;
        o_result.stable_keys = i_stable_keys;
        o_result.ra_cmd      = CMD_NONE;
        o_result.dec_cmd     = CMD_NONE;
        o_result.speed_value = i_item.current_max_speed;

        if (i_accept) begin
            if (!i_item.move_active) begin
                if (!k[KEY_1] && !k[KEY_2]) begin
                    o_result.unpark_req = i_item.parked && !k[KEY_SW];

                    // right ascension axis
                    if (k[KEY_3] || k[KEY_4]) begin
                        n_saved_speed        = o_result.speed_value;
                        o_result.speed_value = manual_speed;
                        o_result.speed_write = 1'b1;
                        o_result.ra_cmd      = CMD_ACCEL;
                        o_result.ra_dir      = k[KEY_3] ? i_cfg.west_dir : i_cfg.east_dir;
                    end else begin
                        o_result.ra_cmd = CMD_DECEL;
                    end

                    // declination axis, saves the limit as ra left it
                    if (k[KEY_5] || k[KEY_6]) begin
                        n_saved_speed        = o_result.speed_value;
                        o_result.speed_value = manual_speed;
                        o_result.speed_write = 1'b1;
                        o_result.dec_cmd     = CMD_ACCEL;
                        o_result.dec_dir     = k[KEY_5] ? r_north_bit : ~r_north_bit;
                    end else begin
                        o_result.dec_cmd = CMD_DECEL;
                    end

                    // all motion keys up: restore the saved limit
                    if (!(k[KEY_3] || k[KEY_4] || k[KEY_5] || k[KEY_6]) &&
                        (r_saved_speed != '0)) begin
                        o_result.speed_value = r_saved_speed;
                        o_result.speed_write = 1'b1;
                    end
                end

                // north direction toggle
                if (k[KEY_2]) begin
                    n_north_bit       = ~r_north_bit;
                    o_result.save_req = 1'b1;
                end
            end

            // reticule brightness
            o_result.bright_up   = k[KEY_1] && k[KEY_5];
            o_result.bright_down = k[KEY_1] && k[KEY_6];
        end

        o_result.north_dir = n_north_bit;
    end

    // decoder state, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved_speed <= '0;
            r_north_bit   <= 1'b0;
        end else if (i_advance) begin
            r_saved_speed <= n_saved_speed;
            r_north_bit   <= n_north_bit;
        end
    end

endmodule
`default_nettype wire

[rtl/hand_pad_debounce_command_decoder_top.sv]
// top level of the hand-pad debounce and command decoder
//
// Input channel i_in_valid/o_in_ready carries one key poll per transaction
// (raw active-low keys, tick count, slew and park flags, current speed limit).
// Output channel o_out_valid/i_out_ready returns exactly one result per poll:
// debounced keys, per-axis commands, speed override and request pulses.
// Configuration channel i_cfg_valid/o_cfg_ready writes one register per
// transaction by index; it is always ready and takes effect at once.
// A poll is held in the input register and decoded, and its result is
// loaded into the result register, which o_out_valid and o_out_item present.
// Throughput: one poll per cycle while the receiver keeps taking results;
// the decode is a single combinational pass between the input register
// and the result register.
// When the receiver stalls, the result register holds, the input register
// fills next, and o_in_ready drops only when both are occupied.
// Reset (i_rst_n low, synchronous) empties both registers, clears the key
// history, saved speed and north bit, and loads the register defaults.
`default_nettype none
`include "hand_pad_debounce_command_decoder_top_defines.svh"
module hand_pad_debounce_command_decoder_top
    import hpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             advance;
    logic             accept;
    logic [KEY_W-1:0] keys;
    logic [KEY_W-1:0] stable_keys;
    t_out_item        result;

    // pipeline handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;
    assign keys        = ~r_in_item.raw_keys_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= RST_DEBOUNCE_TICKS;
            r_cfg.fast_speed      <= RST_FAST_SPEED;
            r_cfg.centering_speed <= RST_CENTERING_SPEED;
            r_cfg.west_dir        <= RST_WEST_DIR;
            r_cfg.east_dir        <= RST_EAST_DIR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_TICKS:  r_cfg.debounce_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_FAST_SPEED:      r_cfg.fast_speed      <= i_cfg_data[SPEED_W-1:0];
                CFG_CENTERING_SPEED: r_cfg.centering_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_WEST_DIR:        r_cfg.west_dir        <= i_cfg_data[0];
                CFG_EAST_DIR:        r_cfg.east_dir        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    hpd_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_keys           (keys),
        .i_tick           (r_in_item.tick_now),
        .i_debounce_ticks (r_cfg.debounce_ticks),
        .o_accept         (accept),
        .o_stable_keys    (stable_keys)
    );

    hpd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_accept      (accept),
        .i_stable_keys (stable_keys),
        .i_item        (r_in_item),
        .i_cfg         (r_cfg),
        .o_result      (result)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    // design checks
    `HPD_ASSERT_NOW(a_ready_low_only_when_full, !o_in_ready,
        r_in_valid && r_out_valid, "input stalled while a register is free")
    `HPD_ASSERT_NOW(a_ra_dir_only_with_accel,
        o_out_valid && (o_out_item.ra_cmd != CMD_ACCEL), !o_out_item.ra_dir,
        "ra direction set without accelerate")
    `HPD_ASSERT_NOW(a_unpark_save_exclusive, o_out_valid,
        !(o_out_item.unpark_req && o_out_item.save_req), "unpark and save in one result")
    `HPD_ASSERT_NEXT(a_advance_fills_output, advance, r_out_valid,
        "advanced transaction lost")

endmodule
`default_nettype wire

[dv/tb_top.sv]
// self-checking testbench for the hand-pad debounce and command decoder
module tb_top
    import hpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // active-high key masks
    localparam logic [KEY_W-1:0] KB_MOD   = KEY_W'(1) << KEY_1;
    localparam logic [KEY_W-1:0] KB_FLIP  = KEY_W'(1) << KEY_2;
    localparam logic [KEY_W-1:0] KB_WEST  = KEY_W'(1) << KEY_3;
    localparam logic [KEY_W-1:0] KB_EAST  = KEY_W'(1) << KEY_4;
    localparam logic [KEY_W-1:0] KB_NORTH = KEY_W'(1) << KEY_5;
    localparam logic [KEY_W-1:0] KB_SOUTH = KEY_W'(1) << KEY_6;
    localparam logic [KEY_W-1:0] KB_SW    = KEY_W'(1) << KEY_SW;
    localparam logic [KEY_W-1:0] KB_NONE  = '0;
    localparam logic [KEY_W-1:0] KB_ALL   = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hand_pad_debounce_command_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // decoder state as the block should hold it
    t_cfg               cur_cfg;
    logic [KEY_W-1:0]   prev_keys;
    logic [KEY_W-1:0]   held_keys;
    logic [TICK_W-1:0]  edge_tick;
    logic [SPEED_W-1:0] memo_speed;
    logic               north_bit;

    // pending decoded commands, oldest first
    t_out_item          pending_cmds[$];

    // stimulus controls
    logic [TICK_W-1:0]  tick_clock = '0;
    bit                 src_idle = 1'b0;
    bit                 sink_idle = 1'b0;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int                 hold_left = 0;

    // run statistics
    int                 n_mismatch = 0;
    int                 n_polls = 0;
    int                 n_results = 0;
    int                 n_key_changes = 0;
    int                 n_speed_writes = 0;
    int                 n_in_stalls = 0;
    int                 n_settings = 0;

    task automatic report_mismatch(string what);
        n_mismatch++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // decoder behavior
    // ---------------------------------------------------------------

    task automatic clear_decoder_state();
        cur_cfg.debounce_ticks  = RST_DEBOUNCE_TICKS;
        cur_cfg.fast_speed      = RST_FAST_SPEED;
        cur_cfg.centering_speed = RST_CENTERING_SPEED;
        cur_cfg.west_dir        = RST_WEST_DIR;
        cur_cfg.east_dir        = RST_EAST_DIR;
        prev_keys  = '0;
        held_keys  = '0;
        edge_tick  = '0;
        memo_speed = '0;
        north_bit  = 1'b0;
    endtask

    function automatic t_out_item decode_poll(t_in_item poll);
        logic [KEY_W-1:0]   keys;
        logic [TICK_W-1:0]  elapsed;
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] manual;
        t_out_item          res;
        keys  = ~poll.raw_keys_n;
        speed = poll.current_max_speed;
        res   = '0;
        // any change of levels restarts the debounce timer
        if (keys != prev_keys)
            edge_tick = poll.tick_now;
        elapsed = poll.tick_now - edge_tick;
        if (elapsed > cur_cfg.debounce_ticks && keys != held_keys) begin
            manual    = keys[KEY_SW] ? cur_cfg.fast_speed : cur_cfg.centering_speed;
            held_keys = keys;
            n_key_changes++;
            if (!poll.move_active) begin
                if (!keys[KEY_1] && !keys[KEY_2]) begin
                    res.unpark_req = poll.parked && !keys[KEY_SW];
                    // right ascension axis
                    if (keys[KEY_3] || keys[KEY_4]) begin
                        memo_speed      = speed;
                        speed           = manual;
                        res.speed_write = 1'b1;
                        res.ra_cmd      = CMD_ACCEL;
                        res.ra_dir      = keys[KEY_3] ? cur_cfg.west_dir : cur_cfg.east_dir;
                    end else begin
                        res.ra_cmd = CMD_DECEL;
                    end
                    // declination axis, a second accelerate saves the manual speed
                    if (keys[KEY_5] || keys[KEY_6]) begin
                        memo_speed      = speed;
                        speed           = manual;
                        res.speed_write = 1'b1;
                        res.dec_cmd     = CMD_ACCEL;
                        res.dec_dir     = keys[KEY_5] ? north_bit : ~north_bit;
                    end else begin
                        res.dec_cmd = CMD_DECEL;
                    end
                    // all motion keys up restores the saved limit
                    if (keys[KEY_6:KEY_3] == '0 && memo_speed != '0) begin
                        speed           = memo_speed;
                        res.speed_write = 1'b1;
                    end
                end
                if (keys[KEY_2]) begin
                    north_bit    = ~north_bit;
                    res.save_req = 1'b1;
                end
            end
            res.bright_up   = keys[KEY_1] && keys[KEY_5];
            res.bright_down = keys[KEY_1] && keys[KEY_6];
        end
        prev_keys       = keys;
        res.stable_keys = held_keys;
        res.speed_value = speed;
        res.north_dir   = north_bit;
        if (res.speed_write)
            n_speed_writes++;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result side: stall pattern and checking
    // ---------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                n_results, name, got, want));
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
        end else begin
            want = pending_cmds.pop_front();
            check_field("stable_keys", 32'(got.stable_keys), 32'(want.stable_keys));
            check_field("ra_cmd",      32'(got.ra_cmd),      32'(want.ra_cmd));
            check_field("ra_dir",      32'(got.ra_dir),      32'(want.ra_dir));
            check_field("dec_cmd",     32'(got.dec_cmd),     32'(want.dec_cmd));
            check_field("dec_dir",     32'(got.dec_dir),     32'(want.dec_dir));
            check_field("speed_write", 32'(got.speed_write), 32'(want.speed_write));
            check_field("speed_value", 32'(got.speed_value), 32'(want.speed_value));
            check_field("unpark_req",  32'(got.unpark_req),  32'(want.unpark_req));
            check_field("save_req",    32'(got.save_req),    32'(want.save_req));
            check_field("north_dir",   32'(got.north_dir),   32'(want.north_dir));
            check_field("bright_up",   32'(got.bright_up),   32'(want.bright_up));
            check_field("bright_down", 32'(got.bright_down), 32'(want.bright_down));
        end
        n_results++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        // compare each accepted transaction with the oldest pending one
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            check_result(o_out_item);
        // long hold-off first, then the random stall pattern
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (sink_idle && stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (sink_idle && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 7);
        end
    end

    // ---------------------------------------------------------------
    // poll and register drivers
    // ---------------------------------------------------------------

    task automatic send_poll(t_in_item poll);
        int gap;
        gap = 0;
        // bursts of random length separated by random gaps
        if (src_idle) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= poll;
        do begin
            @(posedge i_clk);
            if (o_in_ready !== 1'b1)
                n_in_stalls++;
        end while (o_in_ready !== 1'b1);
        pending_cmds.push_back(decode_poll(poll));
        n_polls++;
    endtask

    // wait until every decoded poll has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_DEBOUNCE_TICKS:  cur_cfg.debounce_ticks  = data;
            CFG_FAST_SPEED:      cur_cfg.fast_speed      = data[SPEED_W-1:0];
            CFG_CENTERING_SPEED: cur_cfg.centering_speed = data[SPEED_W-1:0];
            CFG_WEST_DIR:        cur_cfg.west_dir        = data[0];
            CFG_EAST_DIR:        cur_cfg.east_dir        = data[0];
            default: ;
        endcase
    endtask

    // all five registers, upper bits of narrow ones filled with junk
    task automatic apply_settings(t_cfg c, bit poke_unused);
        write_reg(CFG_DEBOUNCE_TICKS, c.debounce_ticks);
        write_reg(CFG_FAST_SPEED,
            {(CFG_DATA_W - SPEED_W)'($urandom()), c.fast_speed});
        write_reg(CFG_CENTERING_SPEED,
            {(CFG_DATA_W - SPEED_W)'($urandom()), c.centering_speed});
        write_reg(CFG_WEST_DIR, {(CFG_DATA_W - 1)'($urandom()), c.west_dir});
        write_reg(CFG_EAST_DIR, {(CFG_DATA_W - 1)'($urandom()), c.east_dir});
        // indexes past the last register must change nothing
        if (poke_unused)
            for (int i = CFG_EAST_DIR + 1; i < 2 ** CFG_IDX_W; i++)
                write_reg(CFG_IDX_W'(i), $urandom());
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic t_cfg make_cfg(logic [TICK_W-1:0] db, logic [SPEED_W-1:0] fast,
                                      logic [SPEED_W-1:0] slow, logic west, logic east);
        t_cfg c;
        c.debounce_ticks  = db;
        c.fast_speed      = fast;
        c.centering_speed = slow;
        c.west_dir        = west;
        c.east_dir        = east;
        return c;
    endfunction

    function automatic t_cfg rand_cfg();
        logic [TICK_W-1:0] db;
        db = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 2000) : $urandom_range(0, 40);
        return make_cfg(db, SPEED_W'($urandom()), SPEED_W'($urandom()),
                        1'($urandom()), 1'($urandom()));
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SPEED_W'($urandom_range(1, 20));
            default: return SPEED_W'($urandom());
        endcase
    endfunction

    // mostly single keys, pairs and releases, some arbitrary chords
    function automatic logic [KEY_W-1:0] pick_keys();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 4))
            0: k = KB_NONE;
            1: k = KEY_W'(1) << $urandom_range(KEY_1, KEY_6);
            2: k = (KEY_W'(1) << $urandom_range(KEY_1, KEY_6))
                 | (KEY_W'(1) << $urandom_range(KEY_1, KEY_6));
            default: k = KEY_W'($urandom());
        endcase
        k[KEY_SW] = 1'($urandom());
        return k;
    endfunction

    // steps that cross the debounce time within a few polls
    function automatic logic [TICK_W-1:0] hold_step();
        logic [TICK_W-1:0] half;
        half = cur_cfg.debounce_ticks >> 1;
        return half + $urandom_range(0, half) + 1;
    endfunction

    function automatic logic [TICK_W-1:0] bounce_step();
        return $urandom_range(0, cur_cfg.debounce_ticks >> 1);
    endfunction

    task automatic poll_at(logic [KEY_W-1:0] keys, logic moving, logic parked);
        t_in_item poll;
        poll.raw_keys_n        = ~keys;
        poll.tick_now          = tick_clock;
        poll.move_active       = moving;
        poll.parked            = parked;
        poll.current_max_speed = pick_speed();
        send_poll(poll);
    endtask

    // change the levels, then hold them just past the debounce time
    task automatic press(logic [KEY_W-1:0] keys, logic moving, logic parked);
        poll_at(keys, moving, parked);
        tick_clock += cur_cfg.debounce_ticks + 1;
        poll_at(keys, moving, parked);
    endtask

    // bounce, then hold a target chord; now and then pure noise
    task automatic run_key_sequences(int n_target);
        int               sent;
        int               bounces;
        int               holds;
        logic [KEY_W-1:0] target;
        sent = 0;
        while (sent < n_target) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1))
                    tick_clock = $urandom();
                else
                    tick_clock += $urandom_range(0, 3);
                poll_at(KEY_W'($urandom()), 1'($urandom()), 1'($urandom()));
                sent++;
            end else begin
                target  = pick_keys();
                bounces = $urandom_range(0, 2);
                holds   = $urandom_range(2, 4);
                repeat (bounces) begin
                    tick_clock += bounce_step();
                    poll_at(KEY_W'($urandom()), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 3) == 0);
                end
                repeat (holds) begin
                    poll_at(target, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
                    tick_clock += hold_step();
                end
                sent += bounces + holds;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // register defaults straight out of reset
    task automatic test_reset_defaults();
        tick_clock = 32'd20;
        press(KB_EAST | KB_SW, 1'b0, 1'b1);
        press(KB_NONE, 1'b0, 1'b0);
    endtask

    task automatic test_key_decode();
        drain();
        apply_settings(make_cfg(32'd5, 16'hFFFF, 16'h0000, 1'b1, 1'b0), 1'b1);
        press(KB_WEST, 1'b0, 1'b1);
        press(KB_NONE, 1'b0, 1'b0);
        press(KB_EAST | KB_SW, 1'b0, 1'b1);
        press(KB_SOUTH, 1'b0, 1'b0);
        // two accelerates: the manual speed ends up saved, release restores it
        press(KB_WEST | KB_NORTH | KB_SW, 1'b0, 1'b0);
        press(KB_NONE, 1'b0, 1'b1);
        press(KB_FLIP, 1'b0, 1'b0);
        press(KB_MOD | KB_NORTH, 1'b0, 1'b0);
        press(KB_MOD | KB_SOUTH, 1'b1, 1'b0);
        press(KB_WEST, 1'b1, 1'b1);
        press(KB_ALL, 1'b0, 1'b1);
    endtask

    task automatic test_debounce_edges();
        drain();
        // a bounce restarts the timer; exactly the debounce time is not enough
        tick_clock = 32'd50;
        poll_at(KB_NORTH, 1'b0, 1'b0);
        tick_clock = 32'd54;
        poll_at(KB_SOUTH, 1'b0, 1'b0);
        tick_clock = 32'd56;
        poll_at(KB_NORTH, 1'b0, 1'b0);
        tick_clock = 32'd61;
        poll_at(KB_NORTH, 1'b0, 1'b0);
        tick_clock = 32'd62;
        poll_at(KB_NORTH, 1'b0, 1'b0);
        // elapsed ticks measured across the counter wrap
        tick_clock = 32'hFFFF_FFFE;
        poll_at(KB_EAST, 1'b0, 1'b0);
        tick_clock += 5;
        poll_at(KB_EAST, 1'b0, 1'b0);
        tick_clock += 1;
        poll_at(KB_EAST, 1'b0, 1'b0);
        // zero debounce: same tick holds, next tick accepts
        drain();
        apply_settings(make_cfg(32'd0, 16'd1, 16'd2, 1'b0, 1'b0), 1'b0);
        poll_at(KB_WEST, 1'b0, 1'b0);
        poll_at(KB_WEST, 1'b0, 1'b0);
        tick_clock += 1;
        poll_at(KB_WEST, 1'b0, 1'b0);
        // largest debounce never accepts
        drain();
        apply_settings(make_cfg(32'hFFFF_FFFF, 16'd3, 16'd4, 1'b1, 1'b1), 1'b0);
        poll_at(KB_NONE, 1'b0, 1'b0);
        tick_clock += 32'h8000_0000;
        poll_at(KB_NONE, 1'b0, 1'b0);
        tick_clock += 32'h7FFF_FFFF;
        poll_at(KB_NONE, 1'b0, 1'b0);
    endtask

    // receiver holds off while polls keep coming, so the input must stall
    task automatic test_backpressure();
        drain();
        apply_settings(make_cfg(32'd3, 16'd300, 16'd7, 1'b0, 1'b1), 1'b0);
        src_idle   = 1'b0;
        sink_idle  = 1'b0;
        tick_clock = 32'd100;
        hold_left  = 60;
        run_key_sequences(30);
    endtask

    task automatic test_random_sequences();
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            if (ph == 0)
                apply_settings(make_cfg(32'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b1), 1'b0);
            else
                apply_settings(rand_cfg(), ph == 2);
            // phase 1 runs with no idling on either side
            src_idle   = (ph != 1);
            sink_idle  = (ph == 0 || ph == 3);
            tick_clock = $urandom_range(0, 1) ? 32'hFFFF_FF00 : $urandom();
            run_key_sequences(400);
        end
    endtask

    initial begin
        clear_decoder_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_key_decode();
        test_debounce_edges();
        test_backpressure();
        test_random_sequences();
        drain();
        // latency of two registers, with margin
        repeat (10) @(posedge i_clk);
        $display("covered %0d polls, %0d debounced key changes, %0d speed writes",
            n_polls, n_key_changes, n_speed_writes);
        $display("%0d register settings, %0d cycles with the input held off",
            n_settings, n_in_stalls);
        if (n_mismatch == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_cmds.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/hpd_pkg.sv
rtl/hpd_debounce.sv
rtl/hpd_decode.sv
rtl/hand_pad_debounce_command_decoder_top.sv
dv/tb_top.sv
